@@ rtl/tsef_pkg.sv @@
// tsef_pkg: field widths, stream packing and action codes of the triangle shared-edge finder
// no dependencies; imported by the top level and the port checker

package tsef_pkg;

   // field widths
   localparam int ELEM_W  = 10;
   localparam int VERT_W  = 16;
   localparam int COUNT_W = 11;

   // stream data widths, padded to whole bytes
   localparam int REQ_FIELDS_W = ELEM_W + 3 * VERT_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 * ELEM_W + 2 * VERT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // request action codes (carried in req_tuser)
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_SCAN = 1'b1;

endpackage

@@ rtl/tsef_ram.sv @@
// tsef_ram: generic single-write, single-read synchronous ram with registered read data
// no dependencies; holds the triangle table of the shared-edge finder

module tsef_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/triangle_shared_edge_finder.sv @@
// triangle_shared_edge_finder: triangle table in ram, load and neighbour scan of one triangle
// depends on tsef_pkg (widths, action codes) and tsef_ram (triangle table)
//
//   channel | dir | handshake               | payload
//   req     | in  | req_tvalid / req_tready | tuser action, tdata index and three vertices
//   rsp     | out | rsp_tvalid / rsp_tready | tuser found, tlast end of scan, tdata pair+edge
//   csr     | in  | csr_wr_en               | csr_wr_data triangle count
//
// a load is written to the table as it is accepted; a scan of triangle i below the clamped count
// reads i and then walks j from i + 1 while j is below the count, the single ram read port
// streaming one stored triangle per cycle unless the pipeline is frozen; it ends earlier at the
// third neighbour, and a scan at or beyond the count goes straight to its final not-found result
// one transaction is in work at a time; req_tready is high only between transactions
// a full output register with a second match waiting freezes the scan pipeline in place
// reset is synchronous and clears control state only; the table is undefined until loaded
// loads and scans never overlap, so ram reads and writes need no forwarding

module triangle_shared_edge_finder
   import tsef_pkg::*;
#(
   parameter int MAX_ELEMS = 1024,
   parameter int VERT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,   // action
   input  logic [REQ_DATA_W-1:0] req_tdata,   // elem_index, vert_a, vert_b, vert_c, zero pad
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tuser,   // found
   output logic                  rsp_tlast,   // last result of the scan
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // first_elem, second_elem, edge_start, edge_end,
                                              // zero pad
   // configuration
   input  logic                  csr_wr_en,
   input  logic [COUNT_W-1:0]    csr_wr_data  // elem_count
);

   localparam int AW = $clog2(MAX_ELEMS);
   localparam int JW = (AW > COUNT_W) ? AW : COUNT_W;
   localparam int CW = JW + 1;
   localparam int TW = 3 * VERT_BITS;
   localparam logic [CW-1:0] MAX_V = CW'(MAX_ELEMS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   // walk i's vertices against j's in order, stop at the second equal pair
   function automatic logic [2*VERT_BITS:0] edge_match(input logic [TW-1:0] t,
                                                       input logic [TW-1:0] u);
      logic [1:0]           hits;
      logic [VERT_BITS-1:0] s;
      logic [VERT_BITS-1:0] e;
      logic [VERT_BITS-1:0] tk;
      logic                 swap;
      hits = 2'd0;
      s    = '0;
      e    = '0;
      for (int k = 0; k < 3; k++) begin
         tk = t[k*VERT_BITS +: VERT_BITS];
         for (int m = 0; m < 3; m++) begin
            if (hits != 2'd2 && tk == u[m*VERT_BITS +: VERT_BITS]) begin
               if (hits == 2'd0) begin
                  s = tk;
               end else begin
                  e = tk;
               end
               hits = hits + 2'd1;
            end
         end
      end
      // edge between vertex 2 and vertex 0 runs from 2 to 0
      swap = (s == t[0 +: VERT_BITS]) && (e == t[2*VERT_BITS +: VERT_BITS]);
      if (swap) begin
         return {hits == 2'd2, e, s};
      end
      return {hits == 2'd2, s, e};
   endfunction

   logic [1:0]           state_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [ELEM_W-1:0]    idx_ff;
   logic [TW-1:0]        tri_i_ff;
   logic [CW-1:0]        j_rd_ff;
   logic [CW-1:0]        j_cmp_ff;
   logic                 cmp_vld_ff;
   logic [1:0]           nfound_ff;
   logic                 pend_vld_ff;
   logic [ELEM_W-1:0]    pend_second_ff;
   logic [VERT_W-1:0]    pend_start_ff;
   logic [VERT_W-1:0]    pend_end_ff;
   logic                 rsp_vld_ff;
   logic                 rsp_found_ff;
   logic                 rsp_last_ff;
   logic [ELEM_W-1:0]    rsp_first_ff;
   logic [ELEM_W-1:0]    rsp_second_ff;
   logic [VERT_W-1:0]    rsp_start_ff;
   logic [VERT_W-1:0]    rsp_end_ff;

   logic [ELEM_W-1:0]    req_idx;
   logic [TW-1:0]        req_tri;
   logic                 req_fire;
   logic                 scan_fire;
   logic                 load_en;
   logic [CW-1:0]        cnt_ext;
   logic [CW-1:0]        cnt_eff;
   logic [TW-1:0]        rd_data;
   logic [2*VERT_BITS:0] cmp_res;
   logic                 match;
   logic [VERT_W-1:0]    match_start;
   logic [VERT_W-1:0]    match_end;
   logic                 out_free;
   logic                 advance;
   logic                 issue;
   logic                 scan_done;
   logic                 rsp_load;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;

   // request unpacking, vertices trimmed or widened to the stored width
   assign req_idx = req_tdata[ELEM_W-1:0];
   assign req_tri = {VERT_BITS'(req_tdata[ELEM_W+2*VERT_W +: VERT_W]),
                     VERT_BITS'(req_tdata[ELEM_W+VERT_W   +: VERT_W]),
                     VERT_BITS'(req_tdata[ELEM_W          +: VERT_W])};

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign scan_fire  = req_fire && (req_tuser == ACT_SCAN);
   assign load_en    = req_fire && (req_tuser == ACT_LOAD) && (CW'(req_idx) < MAX_V);

   // triangle count clamped to the table depth
   assign cnt_ext = CW'(count_ff);
   assign cnt_eff = (cnt_ext > MAX_V) ? MAX_V : cnt_ext;

   // compare stage on the registered ram output
   assign cmp_res     = edge_match(tri_i_ff, rd_data);
   assign match       = (state_ff == ST_SCAN) && cmp_vld_ff && cmp_res[2*VERT_BITS];
   assign match_start = VERT_W'(cmp_res[VERT_BITS +: VERT_BITS]);
   assign match_end   = VERT_W'(cmp_res[0 +: VERT_BITS]);

   // output register and pipeline freeze
   assign out_free  = !rsp_vld_ff || rsp_tready;
   assign advance   = !(match && pend_vld_ff && !out_free);
   assign issue     = ((state_ff == ST_READ) || (state_ff == ST_SCAN && advance)) &&
                      (j_rd_ff < cnt_eff);
   assign scan_done = !cmp_vld_ff && (j_rd_ff >= cnt_eff);
   assign rsp_load  = ((state_ff == ST_SCAN) && match && advance && pend_vld_ff) ||
                      ((state_ff == ST_FIN) && out_free);

   // ram read address: triangle i on accept, then the walk over j
   assign rd_en   = issue || scan_fire;
   assign rd_addr = (state_ff == ST_IDLE) ? AW'(req_idx) : j_rd_ff[AW-1:0];

   tsef_ram #(
      .WIDTH (TW),
      .DEPTH (MAX_ELEMS)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (AW'(req_idx)),
      .wr_data (req_tri),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         cmp_vld_ff  <= 1'b0;
         nfound_ff   <= 2'd0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (rsp_tready && !rsp_load) begin
            rsp_vld_ff <= 1'b0;
         end

         // read pipeline step
         if (issue) begin
            j_rd_ff    <= j_rd_ff + CW'(1);
            j_cmp_ff   <= j_rd_ff;
            cmp_vld_ff <= 1'b1;
         end else if (state_ff == ST_READ || (state_ff == ST_SCAN && advance)) begin
            cmp_vld_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (scan_fire) begin
                  idx_ff  <= req_idx;
                  j_rd_ff <= CW'(req_idx) + CW'(1);
                  state_ff <= (CW'(req_idx) < cnt_eff) ? ST_READ : ST_FIN;
               end
            end
            ST_READ: begin
               tri_i_ff <= rd_data;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (match && advance) begin
                  // earlier match leaves as a middle result
                  if (pend_vld_ff) begin
                     rsp_vld_ff    <= 1'b1;
                     rsp_found_ff  <= 1'b1;
                     rsp_last_ff   <= 1'b0;
                     rsp_first_ff  <= idx_ff;
                     rsp_second_ff <= pend_second_ff;
                     rsp_start_ff  <= pend_start_ff;
                     rsp_end_ff    <= pend_end_ff;
                  end
                  pend_vld_ff    <= 1'b1;
                  pend_second_ff <= ELEM_W'(j_cmp_ff);
                  pend_start_ff  <= match_start;
                  pend_end_ff    <= match_end;
                  nfound_ff      <= nfound_ff + 2'd1;
                  if (nfound_ff == 2'd2) begin
                     state_ff <= ST_FIN;
                  end
               end else if (scan_done) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               // final result: held match or not-found
               if (out_free) begin
                  rsp_vld_ff    <= 1'b1;
                  rsp_found_ff  <= pend_vld_ff;
                  rsp_last_ff   <= 1'b1;
                  rsp_first_ff  <= idx_ff;
                  rsp_second_ff <= pend_vld_ff ? pend_second_ff : '0;
                  rsp_start_ff  <= pend_vld_ff ? pend_start_ff  : '0;
                  rsp_end_ff    <= pend_vld_ff ? pend_end_ff    : '0;
                  pend_vld_ff   <= 1'b0;
                  nfound_ff     <= 2'd0;
                  cmp_vld_ff    <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // result packing
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_FIELDS_W)'(0),
                        rsp_end_ff, rsp_start_ff, rsp_second_ff, rsp_first_ff};

endmodule

@@ rtl/tsef_checker.sv @@
// tsef_checker: port-level assertions for the triangle shared-edge finder, bound to its top
// depends on tsef_pkg (widths); attaches to triangle_shared_edge_finder

module tsef_checker
   import tsef_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // not-found always closes its scan
   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("not-found result without last");

   // not-found carries no neighbour and no edge
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[RSP_DATA_W-1:ELEM_W] == '0)
      else $error("not-found result with neighbour data");

   // reset empties the output register
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind triangle_shared_edge_finder tsef_checker u_tsef_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tdata  (rsp_tdata)
);
